FILE: rtl/glzw_pkg.sv
// Shared types and constants of the GIF LZW compressor.
// Used by glzw_packer and gif_lzw_compressor; depends on nothing.
package glzw_pkg;

  // Register value after reset
  localparam logic [3:0] RESET_MIN_SIZE = 4'd8;
  // Multiplier of the dictionary hash
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  // Requests from the control sequencer to the bit packer
  typedef enum logic [1:0] {
    PK_PUT,
    PK_FLUSH,
    PK_END
  } pk_kind_t;

  typedef struct packed {
    logic     valid;
    pk_kind_t kind;
    logic     stream_end;
  } pk_op_t;

  // Minimum code size clamped to the range 2..8
  function automatic logic [3:0] eff_size(input logic [3:0] sz);
    logic [3:0] r;
    begin
      if (sz < 4'd2) r = 4'd2;
      else if (sz > 4'd8) r = 4'd8;
      else r = sz;
      return r;
    end
  endfunction

endpackage

FILE: rtl/glzw_dict.sv
// Dictionary memory of the GIF LZW compressor: one write port, one read port,
// registered read data. No dependencies.
module glzw_dict #(
  parameter int AW = 13,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/glzw_packer.sv
// LSB-first bit packer with output register of the GIF LZW compressor.
// Holds one byte back so the last byte of each item can be marked.
// Depends on glzw_pkg.
module glzw_packer #(
  parameter int CW = 12,
  parameter int WW = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  glzw_pkg::pk_op_t op,
  input  logic [CW-1:0]   code,
  input  logic [WW-1:0]   width,
  output logic            rdy,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic            out_tuser
);
  import glzw_pkg::*;

  localparam int AccW = CW + 7;
  localparam int CntW = $clog2(CW + 8);

  logic [AccW-1:0] acc_r;
  logic [CntW-1:0] cnt_r;
  logic            flush_r;
  logic [7:0]      pend_r;
  logic            pend_v_r;
  logic            out_v_r;
  logic [7:0]      out_d_r;
  logic            out_l_r;
  logic            out_u_r;

  logic            out_free;
  logic            emit;
  logic            end_take;
  logic            out_load;
  logic [AccW-1:0] cnt_mask;
  logic [CW-1:0]   code_mask;
  logic [AccW-1:0] put_nxt;

  assign out_free  = !out_v_r || out_tready;
  assign emit      = out_free && ((cnt_r >= CntW'(8)) || (flush_r && (cnt_r != '0)));
  assign rdy       = out_free && (cnt_r < CntW'(8)) && !flush_r;
  assign end_take  = op.valid && rdy && (op.kind == PK_END);
  assign out_load  = !clr && pend_v_r && (emit || end_take);
  assign cnt_mask  = (AccW'(1) << cnt_r) - AccW'(1);
  assign code_mask = (CW'(1) << width) - CW'(1);
  assign put_nxt   = (acc_r & cnt_mask) | (AccW'(code & code_mask) << cnt_r);

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;
  assign out_tuser  = out_u_r;

  // packing, byte hold-back and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      flush_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      if (clr) begin
        acc_r    <= '0;
        cnt_r    <= '0;
        flush_r  <= 1'b0;
        pend_v_r <= 1'b0;
      end else if (emit) begin
        if (pend_v_r) begin
          out_d_r <= pend_r;
          out_l_r <= 1'b0;
          out_u_r <= 1'b0;
        end
        pend_r   <= acc_r[7:0];
        pend_v_r <= 1'b1;
        acc_r    <= acc_r >> 8;
        cnt_r    <= (cnt_r > CntW'(8)) ? cnt_r - CntW'(8) : '0;
      end else if (flush_r && (cnt_r == '0)) begin
        flush_r <= 1'b0;
      end else if (op.valid && rdy) begin
        case (op.kind)
          PK_PUT: begin
            acc_r <= put_nxt;
            cnt_r <= cnt_r + CntW'(width);
          end
          PK_FLUSH: begin
            flush_r <= 1'b1;
          end
          PK_END: begin
            if (pend_v_r) begin
              out_d_r  <= pend_r;
              out_l_r  <= 1'b1;
              out_u_r  <= op.stream_end;
              pend_v_r <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/gif_lzw_compressor.sv
// GIF LZW compressor, top level: sequencer, dictionary and bit packer.
// Depends on glzw_pkg, glzw_dict and glzw_packer.
//
// Usage: the in_ channel takes one palette index per request (in_tdata), with
// in_tlast on the final pixel of an image. The out_ channel gives the packed
// LSB-first code stream one byte per request; out_tlast marks the last byte
// caused by an input pixel and out_tuser the final byte of the image. cfg_
// writes min_code_size and starts a new image; it is always ready.
// One pixel is handled at a time: the (prefix, pixel) key is hashed and the
// dictionary is read and compared, with linear probing of the hash table (one
// read per cycle on the single dictionary read port); then codes go to the
// packer. The first pixel of an image skips the lookup.
// The last pixel adds its end code and flush.
// After reset, a register write, the last pixel of an image or a full code
// table the dictionary is cleared one entry a cycle, and no pixel is taken
// until every entry is cleared. TABLE_SIZE must be a power of two.
// A stalled receiver holds the output byte; the packer and sequencer wait.
module gif_lzw_compressor #(
  parameter int MAX_CODE_BITS = 12,
  parameter int TABLE_SIZE    = 8192
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // pixel_index
  input  logic       in_tlast,   // last_pixel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser,  // stream_end
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data    // min_code_size
);
  import glzw_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = MAX_CODE_BITS;
  localparam int NW = CW + 1;
  localparam int KW = CW + 8;
  localparam int DW = 1 + KW + CW;
  localparam int WW = $clog2(MAX_CODE_BITS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PUTF, ST_HASH, ST_RD, ST_CMP, ST_PUTP, ST_PUTC,
    ST_FIN, ST_PUTL, ST_PUTE, ST_FLUSH, ST_END
  } state_t;

  state_t        state_r;
  logic [3:0]    msz_r;
  logic [AW-1:0] clr_addr_r;
  logic [CW-1:0] prefix_r;
  logic [NW-1:0] nfc_r;
  logic [WW-1:0] width_r;
  logic          clr_pend_r;
  logic          first_r;
  logic          need_clr_r;
  logic [7:0]    px_r;
  logic          last_r;
  logic [AW-1:0] prod_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] probe_r;
  logic          slot_ok_r;

  logic [3:0]    eff;
  logic [3:0]    cfg_eff;
  logic [NW-1:0] cc;
  logic [NW-1:0] top_code;
  logic [WW-1:0] width_after;
  logic [KW-1:0] key;
  logic [31:0]   key_ext;
  logic [AW-1:0] hash_idx;
  logic [7:0]    px_mask;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          ent_valid;
  logic [KW-1:0] ent_key;
  logic [CW-1:0] ent_code;

  pk_op_t        pk_op;
  logic [CW-1:0] pk_code;
  logic          pk_rdy;
  logic          pk_take;

  // code arithmetic
  assign eff      = eff_size(msz_r);
  assign cfg_eff  = eff_size(cfg_data);
  assign cc       = NW'(1) << eff;
  assign px_mask  = 8'((9'd1 << eff) - 9'd1);
  assign top_code = (32'(width_r) >= 32'(CW)) ? (NW'(1) << CW)
                                               : ((NW'(1) << width_r) - NW'(1));
  assign width_after = clr_pend_r ? WW'(eff + 4'd1)
                     : ((nfc_r > top_code) && (32'(width_r) < 32'(CW))) ? width_r + WW'(1)
                     : width_r;

  // hash of the (prefix, pixel) key
  assign key      = {prefix_r, px_r};
  assign key_ext  = 32'(key);
  assign hash_idx = prod_r ^ AW'(key_ext >> 7);

  assign ent_valid = rd_data[DW-1];
  assign ent_key   = rd_data[CW +: KW];
  assign ent_code  = rd_data[CW-1:0];

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign pk_take   = pk_op.valid && pk_rdy;

  // memory and packer requests
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = hash_idx;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = {1'b1, key, CW'(nfc_r)};
    pk_op   = '{valid: 1'b0, kind: PK_PUT, stream_end: 1'b0};
    pk_code = prefix_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
      end
      ST_RD: begin
        rd_en = 1'b1;
      end
      ST_CMP: begin
        rd_en   = ent_valid && (ent_key != key) && (probe_r != AW'(TABLE_SIZE - 1));
        rd_addr = idx_r + AW'(1);
      end
      ST_PUTF, ST_PUTC: begin
        pk_op.valid = 1'b1;
        pk_code     = CW'(cc);
      end
      ST_PUTP: begin
        pk_op.valid = 1'b1;
        wr_en = pk_rdy && slot_ok_r && (nfc_r < (NW'(1) << CW));
      end
      ST_PUTL: begin
        pk_op.valid = 1'b1;
      end
      ST_PUTE: begin
        pk_op.valid = 1'b1;
        pk_code     = CW'(cc + NW'(1));
      end
      ST_FLUSH: begin
        pk_op.valid = 1'b1;
        pk_op.kind  = PK_FLUSH;
      end
      ST_END: begin
        pk_op.valid      = 1'b1;
        pk_op.kind       = PK_END;
        pk_op.stream_end = last_r;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      msz_r      <= RESET_MIN_SIZE;
      clr_addr_r <= '0;
      prefix_r   <= '0;
      nfc_r      <= (NW'(1) << eff_size(RESET_MIN_SIZE)) + NW'(2);
      width_r    <= WW'(eff_size(RESET_MIN_SIZE) + 4'd1);
      clr_pend_r <= 1'b0;
      first_r    <= 1'b1;
      need_clr_r <= 1'b0;
    end else if (cfg_valid) begin
      msz_r      <= cfg_data;
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      prefix_r   <= '0;
      nfc_r      <= (NW'(1) << cfg_eff) + NW'(2);
      width_r    <= WW'(cfg_eff + 4'd1);
      clr_pend_r <= 1'b0;
      first_r    <= 1'b1;
      need_clr_r <= 1'b0;
    end else begin
      if (pk_take && (pk_op.kind == PK_PUT)) begin
        width_r <= width_after;
        if (clr_pend_r) clr_pend_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(TABLE_SIZE - 1)) begin
            state_r    <= ST_IDLE;
            need_clr_r <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            px_r    <= in_tdata & px_mask;
            last_r  <= in_tlast;
            state_r <= first_r ? ST_PUTF : ST_HASH;
          end
        end
        ST_PUTF: begin
          if (pk_rdy) begin
            first_r  <= 1'b0;
            prefix_r <= CW'(px_r);
            state_r  <= ST_FIN;
          end
        end
        ST_HASH: begin
          prod_r  <= AW'(key_ext[AW-1:0] * HASH_MULT[AW-1:0]);
          state_r <= ST_RD;
        end
        ST_RD: begin
          idx_r   <= hash_idx;
          probe_r <= '0;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (!ent_valid) begin
            slot_ok_r <= 1'b1;
            state_r   <= ST_PUTP;
          end else if (ent_key == key) begin
            prefix_r <= ent_code;
            state_r  <= ST_FIN;
          end else if (probe_r == AW'(TABLE_SIZE - 1)) begin
            slot_ok_r <= 1'b0;
            state_r   <= ST_PUTP;
          end else begin
            idx_r   <= idx_r + AW'(1);
            probe_r <= probe_r + AW'(1);
          end
        end
        ST_PUTP: begin
          if (pk_rdy) begin
            prefix_r <= CW'(px_r);
            if (wr_en) begin
              nfc_r   <= nfc_r + NW'(1);
              state_r <= ST_FIN;
            end else begin
              // code table full: restart with a clear code
              nfc_r      <= cc + NW'(2);
              clr_pend_r <= 1'b1;
              need_clr_r <= 1'b1;
              state_r    <= ST_PUTC;
            end
          end
        end
        ST_PUTC: begin
          if (pk_rdy) state_r <= ST_FIN;
        end
        ST_FIN: begin
          state_r <= last_r ? ST_PUTL : ST_END;
        end
        ST_PUTL: begin
          if (pk_rdy) state_r <= ST_PUTE;
        end
        ST_PUTE: begin
          if (pk_rdy) state_r <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (pk_rdy) state_r <= ST_END;
        end
        ST_END: begin
          if (pk_rdy) begin
            if (last_r) begin
              // image done: back to the start state
              prefix_r   <= '0;
              nfc_r      <= cc + NW'(2);
              width_r    <= WW'(eff + 4'd1);
              clr_pend_r <= 1'b0;
              first_r    <= 1'b1;
              clr_addr_r <= '0;
              state_r    <= ST_CLEAR;
            end else if (need_clr_r) begin
              clr_addr_r <= '0;
              state_r    <= ST_CLEAR;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  glzw_dict #(
    .AW(AW),
    .DW(DW)
  ) u_dict (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  glzw_packer #(
    .CW(CW),
    .WW(WW)
  ) u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (cfg_valid),
    .op         (pk_op),
    .code       (pk_code),
    .width      (width_r),
    .rdy        (pk_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: tb/tb_gif_lzw_compressor.sv
// Self-checking testbench of gif_lzw_compressor: directed table, then random images.
// Depends on rtl/glzw_pkg.sv and rtl/gif_lzw_compressor.sv; predicts bytes in-house.
module tb_gif_lzw_compressor;
  timeunit 1ns;
  timeprecision 1ps;
  import glzw_pkg::*;

  localparam int MAX_BITS   = 12;
  localparam int TBL_SIZE   = 8192;
  localparam int DRAIN_CYC  = TBL_SIZE + 64;

  // Idle modes of the run
  typedef enum int {NO_IDLE, SRC_IDLE, SINK_STALL, BOTH_IDLE} idle_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } out_byte_t;

  // Directed stimulus row: a register write or a pixel, with optional typed bytes
  typedef struct {
    bit         is_cfg;
    logic [7:0] value;
    bit         last;
    int         n_typed;
    logic [7:0] typed[4];
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid, in_tready;
  logic [7:0] in_tdata;       // pixel_index
  logic       in_tlast;       // last_pixel
  logic       out_tvalid, out_tready;
  logic [7:0] out_tdata;      // out_byte
  logic       out_tlast;      // run_last
  logic       out_tuser;      // stream_end
  logic       cfg_valid, cfg_ready;
  logic [3:0] cfg_data;

  int         src_idle_pct;
  int         sink_stall_pct;
  int         n_fail;
  out_byte_t  byte_q[$];

  // Predictor state
  logic [3:0]  lzw_size;
  int unsigned lzw_prefix, lzw_next, lzw_width, lzw_acc, lzw_nbits;
  bit          lzw_clr_pend, lzw_first;
  int          lzw_dict[int];
  logic [7:0]  step_bytes[$];

  gif_lzw_compressor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamped code size
  function automatic int unsigned size_eff();
    if (lzw_size < 4'd2) return 2;
    if (lzw_size > 4'd8) return 8;
    return lzw_size;
  endfunction

  function automatic void lzw_init();
    lzw_dict.delete();
    lzw_prefix   = 0;
    lzw_next     = (1 << size_eff()) + 2;
    lzw_width    = size_eff() + 1;
    lzw_acc      = 0;
    lzw_nbits    = 0;
    lzw_clr_pend = 0;
    lzw_first    = 1;
  endfunction

  // Pack one code LSB-first, then grow or restore the width
  function automatic void pack_code(int unsigned code);
    int unsigned top;
    lzw_acc &= (32'd1 << lzw_nbits) - 1;
    lzw_acc |= (code & ((32'd1 << lzw_width) - 1)) << lzw_nbits;
    lzw_nbits += lzw_width;
    while (lzw_nbits >= 8) begin
      step_bytes.push_back(lzw_acc[7:0]);
      lzw_acc >>= 8;
      lzw_nbits -= 8;
    end
    top = (lzw_width >= MAX_BITS) ? (1 << MAX_BITS) : ((1 << lzw_width) - 1);
    if (lzw_clr_pend) begin
      lzw_width    = size_eff() + 1;
      lzw_clr_pend = 0;
    end else if (lzw_next > top && lzw_width < MAX_BITS) begin
      lzw_width++;
    end
  endfunction

  // Compress one accepted pixel and queue the bytes it yields
  function automatic void compress_pixel(logic [7:0] pix, bit last);
    int unsigned cc, px, key;
    out_byte_t   ob;
    cc = 1 << size_eff();
    px = pix & (cc - 1);
    step_bytes.delete();
    if (lzw_first) begin
      lzw_first = 0;
      pack_code(cc);
      lzw_prefix = px;
    end else begin
      key = (lzw_prefix << 8) | px;
      if (lzw_dict.exists(key)) begin
        lzw_prefix = lzw_dict[key];
      end else begin
        pack_code(lzw_prefix);
        lzw_prefix = px;
        if (lzw_next < (1 << MAX_BITS)) begin
          lzw_dict[key] = lzw_next;
          lzw_next++;
        end else begin
          // code table full: restart dictionary with a clear code
          lzw_dict.delete();
          lzw_next     = cc + 2;
          lzw_clr_pend = 1;
          pack_code(cc);
        end
      end
    end
    if (last) begin
      pack_code(lzw_prefix);
      pack_code(cc + 1);
      while (lzw_nbits > 0) begin
        step_bytes.push_back(lzw_acc[7:0]);
        lzw_acc >>= 8;
        lzw_nbits = (lzw_nbits > 8) ? lzw_nbits - 8 : 0;
      end
    end
    foreach (step_bytes[i]) begin
      ob.data       = step_bytes[i];
      ob.run_last   = (i == step_bytes.size() - 1);
      ob.stream_end = last && (i == step_bytes.size() - 1);
      byte_q.push_back(ob);
    end
    if (last) lzw_init();
  endfunction

  // Send one pixel request; called and returning at a rising edge
  task automatic send_pixel(logic [7:0] pix, bit last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tlast  <= last;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    compress_pixel(pix, last);
  endtask

  // Let the block go quiet, then write min_code_size
  task automatic write_size(logic [3:0] sz);
    in_tvalid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    lzw_size = sz;
    lzw_init();
  endtask

  task automatic set_idle(idle_mode_t m);
    src_idle_pct   = (m == SRC_IDLE || m == SINK_STALL) ? ((m == SRC_IDLE) ? 70 : 0)
                                                       : ((m == BOTH_IDLE) ? 17 : 0);
    sink_stall_pct = (m == SINK_STALL) ? 70 : ((m == BOTH_IDLE) ? 17 : 0);
  endtask

  // Receiver readiness
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Byte checker; both handshake signals are settled by the falling edge
  always @(negedge clk) begin
    out_byte_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (byte_q.size() == 0) begin
        $display("%0t: unexpected byte %h last=%b end=%b", $time, out_tdata, out_tlast,
                 out_tuser);
        n_fail++;
      end else begin
        e = byte_q.pop_front();
        if (out_tdata !== e.data || out_tlast !== e.run_last
            || out_tuser !== e.stream_end) begin
          $display("%0t: byte mismatch exp %h/%b/%b got %h/%b/%b", $time, e.data,
                   e.run_last, e.stream_end, out_tdata, out_tlast, out_tuser);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t    rows[$];
    dir_row_t    r;
    int          base, nb, len, alpha;
    logic [3:0]  sz;
    logic [7:0]  pix;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= RESET_MIN_SIZE;
    n_fail    = 0;
    set_idle(NO_IDLE);
    lzw_size  = RESET_MIN_SIZE;
    lzw_init();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // After reset: one-pixel image, clear 256, pixel 0, end 257 in 9-bit codes
    rows.push_back('{0, 8'h00, 1, 4, '{8'h00, 8'h01, 8'h04, 8'h04}});
    // Repeated run hits the dictionary, then extremes of the pixel
    rows.push_back('{0, 8'hFF, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'hFF, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'hFF, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'hFF, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'hAA, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h55, 1, 0, '{default: 0}});
    // Size below range acts as 2: clear 4, pixel 0, end 5 in 3-bit codes
    rows.push_back('{1, 8'd0, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h00, 1, 2, '{8'h44, 8'h01, 8'h00, 8'h00}});
    // Pixels wider than the size are masked
    rows.push_back('{0, 8'hFF, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'hFE, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h03, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h07, 1, 0, '{default: 0}});
    // Size above range acts as 8
    rows.push_back('{1, 8'd15, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h80, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h7F, 1, 0, '{default: 0}});
    rows.push_back('{1, 8'd2, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h01, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h01, 0, 0, '{default: 0}});
    rows.push_back('{0, 8'h02, 1, 0, '{default: 0}});

    @(posedge clk);
    foreach (rows[i]) begin
      r = rows[i];
      if (r.is_cfg) begin
        write_size(r.value[3:0]);
      end else begin
        base = byte_q.size();
        send_pixel(r.value, r.last);
        nb = byte_q.size() - base;
        if (r.n_typed != 0) begin
          if (nb != r.n_typed) begin
            $display("%0t: row %0d yields %0d bytes, exp %0d", $time, i, nb, r.n_typed);
            n_fail++;
          end else begin
            for (int k = 0; k < nb; k++)
              if (byte_q[base + k].data !== r.typed[k]) begin
                $display("%0t: row %0d byte %0d exp %h got %h", $time, i, k, r.typed[k],
                         byte_q[base + k].data);
                n_fail++;
              end
          end
        end
      end
    end

    // Random images across idle modes and code sizes
    for (int ph = 0; ph < 8; ph++) begin
      set_idle(idle_mode_t'(ph % 4));
      case (ph)
        0: sz = 4'd2;
        3: sz = 4'd8;
        5: sz = 4'd0;
        7: sz = 4'd15;
        default: sz = 4'($urandom_range(2, 8));
      endcase
      write_size(sz);
      for (int n = 0; n < 42;) begin
        len   = $urandom_range(1, 30);
        alpha = $urandom_range(1, 1 << size_eff());
        for (int j = 0; j < len; j++, n++) begin
          pix = ($urandom_range(9) < 2) ? 8'($urandom) : 8'($urandom_range(alpha - 1));
          send_pixel(pix, j == len - 1);
          // hold off once mid-image until every byte is out
          if (ph == 2 && n == 20) begin
            in_tvalid <= 1'b0;
            while (byte_q.size() != 0) @(posedge clk);
          end
        end
      end
    end

    in_tvalid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
